// ===== rtl/ellipse_trajectory_generator_unit_defines.svh =====
// Assertion macros used by the trajectory generator controller (etg_ctrl).
`ifndef ELLIPSE_TRAJECTORY_GENERATOR_UNIT_DEFINES_SVH
`define ELLIPSE_TRAJECTORY_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ETG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ETG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/etg_pkg.sv =====
`timescale 1ns / 1ps
package etg_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_LD1, S_ROT1, S_TRIG, S_MUL, S_LDV, S_VEC, S_HEAD, S_LD2, S_ROT2, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_RXS, MUL_RYC, MUL_RXC, MUL_VX, MUL_RYS, MUL_VY
  } mul_op_t;

  localparam logic [2:0] CFG_RADIUS_X     = 3'd0;
  localparam logic [2:0] CFG_RADIUS_Y     = 3'd1;
  localparam logic [2:0] CFG_CENTER_X     = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y     = 3'd3;
  localparam logic [2:0] CFG_HEIGHT       = 3'd4;
  localparam logic [2:0] CFG_ANGULAR_RATE = 3'd5;
  localparam logic [2:0] CFG_PHASE_STEP   = 3'd6;
  localparam logic [2:0] CFG_PHASE_OFFSET = 3'd7;

  localparam logic [31:0] GAIN_Q30  = 32'd652032874;
  localparam logic [31:0] TURN_HALF = 32'h8000_0000;

  typedef struct packed {
    logic       phase_clear;
    logic       phase_adv;
    logic       load_rot1;
    logic       load_vec;
    logic       load_rot2;
    logic       step;
    logic [4:0] iter;
    mul_op_t    mul_op;
    logic       latch_trig;
    logic       latch_head;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_pending;
  } stat_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/etg_ifs.sv =====
`timescale 1ns / 1ps
interface etg_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic sync_value;
  modport source (output valid, output req_type, output sync_value, input ready);
  modport sink (input valid, input req_type, input sync_value, output ready);
endinterface

interface etg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] yaw_rate;
  logic signed [15:0] heading;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, output pos_x, output pos_y, output pos_z, output vel_x,
                  output vel_y, output yaw_rate, output heading, output quat_z,
                  output quat_w, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, input vel_x,
                input vel_y, input yaw_rate, input heading, input quat_z,
                input quat_w, output ready);
endinterface

// ===== rtl/etg_datapath.sv =====
`timescale 1ns / 1ps
module etg_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  etg_pkg::cmd_t     cmd,
  output etg_pkg::stat_t    stat,
  etg_out_if.source         out_chan
);

  logic [30:0]        radius_x_r, radius_y_r;
  logic signed [31:0] center_x_r, center_y_r, height_r, angular_rate_r;
  logic [31:0]        phase_step_r, phase_offset_r, phase_accum_r;

  // shared CORDIC: rotation (z driven) or vectoring (y driven)
  logic signed [63:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic               rot_mode_r, flip_r, vzero_r;

  logic signed [31:0] c_r, s_r;
  logic signed [33:0] rxs_r, ryc_r;
  logic signed [31:0] px_r, py_r, vx_r, vy_r;
  logic [15:0]        hd_r;

  logic signed [65:0] prod_r;
  etg_pkg::mul_op_t   tag_r;

  logic               out_valid_r;
  logic signed [31:0] o_px_r, o_py_r, o_pz_r, o_vx_r, o_vy_r, o_w_r;
  logic signed [15:0] o_hd_r, o_qz_r, o_qw_r;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -67'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // ---- CORDIC combinational step
  logic signed [63:0] sh_x, sh_y, c_full, s_full;
  logic signed [33:0] at;
  logic               pos_dir;
  assign sh_x    = cx_r >>> cmd.iter;
  assign sh_y    = cy_r >>> cmd.iter;
  assign at      = signed'({2'b00, etg_pkg::atan_turn(cmd.iter)});
  assign pos_dir = rot_mode_r ? !cz_r[33] : cy_r[63];
  assign c_full  = flip_r ? -cx_r : cx_r;
  assign s_full  = flip_r ? -cy_r : cy_r;

  // rotation start angle with quadrants 2 and 3 folded by a half turn
  logic [31:0] rot_ang, rot_fold;
  logic        rot_flip;
  assign rot_ang  = cmd.load_rot2 ? {hd_r[15], hd_r, 15'd0} : phase_accum_r + phase_offset_r;
  assign rot_flip = rot_ang[31] ^ rot_ang[30];
  assign rot_fold = rot_flip ? (rot_ang ^ etg_pkg::TURN_HALF) : rot_ang;

  logic signed [63:0] vxe, vye;
  assign vxe = {{4{vx_r[31]}}, vx_r, 28'd0};
  assign vye = {{4{vy_r[31]}}, vy_r, 28'd0};

  // ---- multiplier operands
  logic signed [33:0] op_a;
  logic signed [31:0] op_b;
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.mul_op)
      etg_pkg::MUL_RXS: begin op_a = signed'({3'b000, radius_x_r}); op_b = s_r; end
      etg_pkg::MUL_RYC: begin op_a = signed'({3'b000, radius_y_r}); op_b = c_r; end
      etg_pkg::MUL_RXC: begin op_a = signed'({3'b000, radius_x_r}); op_b = c_r; end
      etg_pkg::MUL_RYS: begin op_a = signed'({3'b000, radius_y_r}); op_b = s_r; end
      etg_pkg::MUL_VX:  begin op_a = rxs_r; op_b = angular_rate_r; end
      etg_pkg::MUL_VY:  begin op_a = ryc_r; op_b = angular_rate_r; end
      default: ;
    endcase
  end

  logic signed [65:0] r30_w, r16_w;
  logic signed [33:0] r30;
  assign r30_w = (prod_r + 66'sd536870912) >>> 30;
  assign r30   = r30_w[33:0];
  assign r16_w = (prod_r + 66'sd32768) >>> 16;

  // quaternion parts to Q1.14 with clamp
  logic signed [33:0] qz_sh, qw_sh;
  logic signed [15:0] qz, qw;
  assign qz_sh = (signed'(s_full[33:0]) + 34'sd32768) >>> 16;
  assign qw_sh = (signed'(c_full[33:0]) + 34'sd32768) >>> 16;
  always_comb begin
    qz = (qz_sh > 34'sd16384) ? 16'sd16384 :
         (qz_sh < -34'sd16384) ? -16'sd16384 : qz_sh[15:0];
    qw = (qw_sh > 34'sd16384) ? 16'sd16384 :
         (qw_sh < -34'sd16384) ? -16'sd16384 : qw_sh[15:0];
  end

  logic [31:0] hd_round;
  assign hd_round = cz_r[31:0] + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_x_r     <= 31'd65536;
      radius_y_r     <= 31'd131072;
      center_x_r     <= '0;
      center_y_r     <= '0;
      height_r       <= 32'sd65536;
      angular_rate_r <= 32'sd20587;
      phase_step_r   <= 32'd715828;
      phase_offset_r <= '0;
      phase_accum_r  <= '0;
      tag_r          <= etg_pkg::MUL_NONE;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          etg_pkg::CFG_RADIUS_X:     radius_x_r     <= cfg_wdata[30:0];
          etg_pkg::CFG_RADIUS_Y:     radius_y_r     <= cfg_wdata[30:0];
          etg_pkg::CFG_CENTER_X:     center_x_r     <= cfg_wdata;
          etg_pkg::CFG_CENTER_Y:     center_y_r     <= cfg_wdata;
          etg_pkg::CFG_HEIGHT:       height_r       <= cfg_wdata;
          etg_pkg::CFG_ANGULAR_RATE: angular_rate_r <= cfg_wdata;
          etg_pkg::CFG_PHASE_STEP:   phase_step_r   <= cfg_wdata;
          etg_pkg::CFG_PHASE_OFFSET: phase_offset_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.phase_clear) phase_accum_r <= '0;
      else if (cmd.phase_adv) phase_accum_r <= phase_accum_r + phase_step_r;
      tag_r <= cmd.mul_op;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rot1 || cmd.load_rot2) begin
      cx_r       <= 64'(etg_pkg::GAIN_Q30);
      cy_r       <= '0;
      cz_r       <= signed'({{2{rot_fold[31]}}, rot_fold});
      flip_r     <= rot_flip;
      rot_mode_r <= 1'b1;
    end else if (cmd.load_vec) begin
      cx_r       <= vx_r[31] ? -vxe : vxe;
      cy_r       <= vx_r[31] ? -vye : vye;
      cz_r       <= vx_r[31] ? signed'({2'b00, etg_pkg::TURN_HALF}) : '0;
      flip_r     <= 1'b0;
      vzero_r    <= (vx_r == 0) && (vy_r == 0);
      rot_mode_r <= 1'b0;
    end else if (cmd.step) begin
      if (pos_dir) begin
        cx_r <= cx_r - sh_y;
        cy_r <= cy_r + sh_x;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + sh_y;
        cy_r <= cy_r - sh_x;
        cz_r <= cz_r + at;
      end
    end
    if (cmd.latch_trig) begin
      c_r <= c_full[31:0];
      s_r <= s_full[31:0];
    end
    if (cmd.latch_head) hd_r <= vzero_r ? 16'd0 : hd_round[31:16];
    prod_r <= op_a * op_b;
    unique case (tag_r)
      etg_pkg::MUL_RXS: rxs_r <= r30;
      etg_pkg::MUL_RYC: ryc_r <= r30;
      etg_pkg::MUL_RXC: px_r  <= sat32(67'(r30) + 67'(center_x_r));
      etg_pkg::MUL_RYS: py_r  <= sat32(67'(r30) + 67'(center_y_r));
      etg_pkg::MUL_VX:  vx_r  <= sat32(-67'(r16_w));
      etg_pkg::MUL_VY:  vy_r  <= sat32(67'(r16_w));
      default: ;
    endcase
    if (cmd.out_load) begin
      o_px_r <= px_r;
      o_py_r <= py_r;
      o_pz_r <= height_r;
      o_vx_r <= vx_r;
      o_vy_r <= vy_r;
      o_w_r  <= angular_rate_r;
      o_hd_r <= hd_r;
      o_qz_r <= qz;
      o_qw_r <= qw;
    end
  end

  assign stat.out_pending = out_valid_r;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.pos_x    = o_px_r;
  assign out_chan.pos_y    = o_py_r;
  assign out_chan.pos_z    = o_pz_r;
  assign out_chan.vel_x    = o_vx_r;
  assign out_chan.vel_y    = o_vy_r;
  assign out_chan.yaw_rate = o_w_r;
  assign out_chan.heading  = o_hd_r;
  assign out_chan.quat_z   = o_qz_r;
  assign out_chan.quat_w   = o_qw_r;

endmodule

// ===== rtl/etg_ctrl.sv =====
`timescale 1ns / 1ps
`include "ellipse_trajectory_generator_unit_defines.svh"
module etg_ctrl #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  etg_in_if.sink         in_chan,
  input  etg_pkg::stat_t stat,
  output etg_pkg::cmd_t  cmd
);

  localparam int CW = $clog2(CORDIC_STAGES);
  localparam logic [CW-1:0] LAST_ITER = CW'(CORDIC_STAGES - 1);
  localparam logic [CW-1:0] LAST_MUL  = CW'(6);

  etg_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            running_r, running_nxt;
  logic            tick_go, iter_st;

  assign tick_go = in_chan.valid && in_chan.ready && !in_chan.req_type && running_r;
  assign iter_st = (state_r == etg_pkg::S_ROT1) || (state_r == etg_pkg::S_VEC) ||
                   (state_r == etg_pkg::S_ROT2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= etg_pkg::S_IDLE;
      cnt_r     <= '0;
      running_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      running_r <= running_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    running_nxt    = running_r;
    cmd            = '0;
    cmd.mul_op     = etg_pkg::MUL_NONE;
    cmd.iter       = 5'(cnt_r);
    in_chan.ready  = 1'b0;
    unique case (state_r)
      etg_pkg::S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          if (in_chan.req_type) begin
            running_nxt     = in_chan.sync_value;
            cmd.phase_clear = in_chan.sync_value;
          end else if (running_r) begin
            cmd.phase_adv = 1'b1;
            state_nxt     = etg_pkg::S_LD1;
          end
        end
      end
      etg_pkg::S_LD1: begin
        cmd.load_rot1 = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = etg_pkg::S_ROT1;
      end
      etg_pkg::S_ROT1: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_ITER) state_nxt = etg_pkg::S_TRIG;
      end
      etg_pkg::S_TRIG: begin
        cmd.latch_trig = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = etg_pkg::S_MUL;
      end
      etg_pkg::S_MUL: begin
        // rounded products must be back before the velocity terms use them
        unique case (cnt_r)
          CW'(0):  cmd.mul_op = etg_pkg::MUL_RXS;
          CW'(1):  cmd.mul_op = etg_pkg::MUL_RYC;
          CW'(2):  cmd.mul_op = etg_pkg::MUL_RXC;
          CW'(3):  cmd.mul_op = etg_pkg::MUL_VX;
          CW'(4):  cmd.mul_op = etg_pkg::MUL_RYS;
          CW'(5):  cmd.mul_op = etg_pkg::MUL_VY;
          default: cmd.mul_op = etg_pkg::MUL_NONE;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_MUL) state_nxt = etg_pkg::S_LDV;
      end
      etg_pkg::S_LDV: begin
        cmd.load_vec = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = etg_pkg::S_VEC;
      end
      etg_pkg::S_VEC: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_ITER) state_nxt = etg_pkg::S_HEAD;
      end
      etg_pkg::S_HEAD: begin
        cmd.latch_head = 1'b1;
        state_nxt      = etg_pkg::S_LD2;
      end
      etg_pkg::S_LD2: begin
        cmd.load_rot2 = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = etg_pkg::S_ROT2;
      end
      etg_pkg::S_ROT2: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_ITER) state_nxt = etg_pkg::S_FIN;
      end
      etg_pkg::S_FIN: begin
        if (!stat.out_pending) begin
          cmd.out_load = 1'b1;
          state_nxt    = etg_pkg::S_IDLE;
        end
      end
      default: state_nxt = etg_pkg::S_IDLE;
    endcase
  end

  `ETG_ASSERT_NOW(a_load_free, cmd.out_load, !stat.out_pending, "result overwritten")
  `ETG_ASSERT_NEXT(a_tick_starts, tick_go, state_r == etg_pkg::S_LD1, "tick did not start")
  `ETG_ASSERT_NOW(a_step_state, cmd.step, iter_st, "CORDIC step outside iteration")

endmodule

// ===== rtl/ellipse_trajectory_generator_unit.sv =====
`timescale 1ns / 1ps
// channel   dir   transaction contents
// in_chan   in    req_type, sync_value
// out_chan  out   pos_x/y/z, vel_x/y, yaw_rate, heading, quat_z/w
// cfg_*     in    cfg_we, cfg_index, cfg_wdata (no handshake)
// A tick while running uses the one shared CORDIC three times (rotation, vectoring,
// rotation) plus the single multiplier six times.
// A sync, or a tick while stopped, is taken while idle and gives no result.
// Reset (synchronous, rst_n low) restores the register defaults and stops the block.
// A result not yet taken holds the finish step; input is taken only while idle.
module ellipse_trajectory_generator_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  etg_in_if.sink      in_chan,
  etg_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  etg_pkg::cmd_t  cmd;
  etg_pkg::stat_t stat;

  etg_ctrl #(.CORDIC_STAGES(CORDIC_STAGES)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .stat    (stat),
    .cmd     (cmd)
  );

  etg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_chan  (out_chan)
  );

endmodule

// ===== verif/etg_tb_ifs.sv =====
`timescale 1ns / 1ps
interface etg_tb_cfg_if;
  logic        we;
  logic [2:0]  index;
  logic [31:0] wdata;
endinterface

// ===== verif/etg_traj_checker.sv =====
`timescale 1ns / 1ps
module etg_traj_checker #(
  parameter int STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  etg_in_if         in_mon,
  etg_out_if        out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending_points
);

  typedef struct packed {
    logic signed [31:0] px, py, pz, vx, vy, yr;
    logic signed [15:0] hd, qz, qw;
  } traj_point_t;

  logic [30:0] rad_x, rad_y;
  logic [31:0] cen_x, cen_y, hgt, rate, pstep, poffs, phase;
  logic        moving;
  traj_point_t want_q[$];

  localparam logic [31:0] TURN_TBL [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  function automatic longint rnd_sh(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void sincos(logic [31:0] ang, output longint c, output longint s);
    logic   flip;
    longint x, y, z, dx, dy;
    flip = ang[31] ^ ang[30];
    if (flip) ang = ang ^ etg_pkg::TURN_HALF;
    x = longint'(etg_pkg::GAIN_Q30);
    y = 0;
    z = longint'(signed'(ang));
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(TURN_TBL[i]);
      end else begin
        x += dx; y -= dy; z += longint'(TURN_TBL[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [15:0] bearing(longint vx, longint vy);
    logic [31:0] z;
    longint      x, y, dx, dy;
    logic [31:0] r;
    if (vx == 0 && vy == 0) return 16'd0;
    z = 32'd0;
    x = vx <<< 28;
    y = vy <<< 28;
    if (x < 0) begin
      x = -x; y = -y; z = etg_pkg::TURN_HALF;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z = z + TURN_TBL[i];
      end else begin
        x -= dx; y += dy; z = z - TURN_TBL[i];
      end
    end
    r = z + 32'h8000;
    return r[31:16];
  endfunction

  function automatic logic [15:0] q14(longint v);
    v = rnd_sh(v, 16);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return 16'(v);
  endfunction

  function automatic traj_point_t next_point(logic [31:0] ang);
    traj_point_t p;
    longint c, s, w, qc, qs;
    logic [15:0] h;
    sincos(ang, c, s);
    w = longint'(signed'(rate));
    p.px = 32'(sat(rnd_sh(longint'(rad_x) * c, 30) + longint'(signed'(cen_x))));
    p.py = 32'(sat(rnd_sh(longint'(rad_y) * s, 30) + longint'(signed'(cen_y))));
    p.pz = hgt;
    p.vx = 32'(sat(-rnd_sh(rnd_sh(longint'(rad_x) * s, 30) * w, 16)));
    p.vy = 32'(sat(rnd_sh(rnd_sh(longint'(rad_y) * c, 30) * w, 16)));
    p.yr = rate;
    h = bearing(longint'(p.vx), longint'(p.vy));
    p.hd = h;
    sincos({h[15], h, 15'd0}, qc, qs);
    p.qz = q14(qs);
    p.qw = q14(qc);
    return p;
  endfunction

  assign pending_points = want_q.size();

  always @(posedge clk) begin
    traj_point_t got, exp_p;
    logic [31:0] nxt;
    if (!rst_n) begin
      rad_x <= 31'd65536; rad_y <= 31'd131072; cen_x <= '0; cen_y <= '0;
      hgt <= 32'd65536; rate <= 32'd20587; pstep <= 32'd715828; poffs <= '0;
      phase <= '0; moving <= 1'b0; fail_count <= 0;
      want_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          etg_pkg::CFG_RADIUS_X:     rad_x <= cfg_wdata[30:0];
          etg_pkg::CFG_RADIUS_Y:     rad_y <= cfg_wdata[30:0];
          etg_pkg::CFG_CENTER_X:     cen_x <= cfg_wdata;
          etg_pkg::CFG_CENTER_Y:     cen_y <= cfg_wdata;
          etg_pkg::CFG_HEIGHT:       hgt <= cfg_wdata;
          etg_pkg::CFG_ANGULAR_RATE: rate <= cfg_wdata;
          etg_pkg::CFG_PHASE_STEP:   pstep <= cfg_wdata;
          etg_pkg::CFG_PHASE_OFFSET: poffs <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.req_type) begin
          moving <= in_mon.sync_value;
          if (in_mon.sync_value) phase <= '0;
        end else if (moving) begin
          nxt = phase + pstep;
          phase <= nxt;
          want_q.push_back(next_point(nxt + poffs));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.pos_x, out_mon.pos_y, out_mon.pos_z, out_mon.vel_x,
                out_mon.vel_y, out_mon.yaw_rate, out_mon.heading, out_mon.quat_z,
                out_mon.quat_w};
        if (want_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected transaction: %p", got);
        end else begin
          exp_p = want_q.pop_front();
          if (got !== exp_p) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: expected %p got %p", exp_p, got);
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_ellipse_trajectory_generator_unit.sv =====
`timescale 1ns / 1ps
module tb_ellipse_trajectory_generator_unit;

  localparam int LATENCY = 3 * 16 + 15;
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic clk;
  logic rst_n;
  int   fail_count, pending_points;
  longint cycles;
  int   burst_left, gap_left, stall_phase;
  logic [31:0] stall_mask;

  etg_in_if     in_chan();
  etg_out_if    out_chan();
  etg_tb_cfg_if cfg();

  ellipse_trajectory_generator_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_wdata(cfg.wdata)
  );

  etg_traj_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_wdata(cfg.wdata),
    .fail_count(fail_count), .pending_points(pending_points)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= (!rst_n) ? 0 : cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern: a rotating mask, reseeded now and then, sometimes all-ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_phase <= 0;
      stall_mask <= '1;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 200 == 199)
        stall_mask <= ($urandom_range(0, 2) == 0) ? '1 : $urandom;
      out_chan.ready <= stall_mask[stall_phase % 32];
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg.we <= 1'b1; cfg.index <= idx; cfg.wdata <= val;
    @(posedge clk);
    cfg.we <= 1'b0;
    @(posedge clk);
  endtask

  // wait until the block is idle before touching registers
  task automatic drain();
    if (burst_left != 0) begin
      in_chan.valid <= 1'b0;
      burst_left = 0;
    end
    while (pending_points != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // one transaction, with bursty gaps on the sender side
  task automatic send_item(logic rt, logic sv);
    if (burst_left == 0) begin
      gap_left = $urandom_range(1, 80);
      while (gap_left > 0) begin
        @(posedge clk);
        gap_left--;
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_chan.valid <= 1'b1; in_chan.req_type <= rt; in_chan.sync_value <= sv;
    do @(posedge clk); while (!in_chan.ready);
    if (burst_left == 0) in_chan.valid <= 1'b0;
  endtask

  task automatic random_setting(int kind);
    logic [31:0] r;
    for (int i = 0; i < 8; i++) begin
      case (kind)
        0: r = $urandom;
        1: r = (i == 6 || i == 7) ? $urandom : 32'hFFFF_FFFF;
        2: r = (i < 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: r = $urandom_range(0, 32'h0004_0000) - ((i >= 2) ? 32'h0002_0000 : 0);
      endcase
      write_reg(3'(i), r);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0; in_chan.req_type = 1'b0; in_chan.sync_value = 1'b0;
    cfg.we = 1'b0; cfg.index = etg_pkg::CFG_RADIUS_X; cfg.wdata = '0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ticks while stopped, start, stop keeps phase, restart clears
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b1);
    repeat (4) send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b0);
    drain();
    // zero velocity, heading pi, quarter-turn phases, extremes
    write_reg(etg_pkg::CFG_ANGULAR_RATE, 32'd0);
    write_reg(etg_pkg::CFG_PHASE_STEP, 32'h4000_0000);
    repeat (4) send_item(1'b0, 1'b0);
    drain();
    write_reg(etg_pkg::CFG_ANGULAR_RATE, 32'hFFFF_0000);
    write_reg(etg_pkg::CFG_PHASE_OFFSET, 32'h2000_0000);
    repeat (3) send_item(1'b0, 1'b0);
    drain();
    random_setting(2);
    repeat (3) send_item(1'b0, 1'b0);
    drain();
    random_setting(1);
    send_item(1'b0, 1'b0);
    drain();
    write_reg(etg_pkg::CFG_PHASE_OFFSET, 32'h0);

    for (int ph = 0; ph < 16; ph++) begin
      drain();
      random_setting(ph == 5 ? 1 : (ph == 9 ? 2 : (ph % 2 == 0 ? 3 : 0)));
      send_item(1'b1, 1'b1);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 19) == 0) send_item(1'b1, 1'($urandom_range(0, 1)));
        else send_item(1'b0, 1'($urandom_range(0, 1)));
      end
    end
    drain();

    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/etg_pkg.sv
rtl/etg_ifs.sv
rtl/etg_datapath.sv
rtl/etg_ctrl.sv
rtl/ellipse_trajectory_generator_unit.sv
verif/etg_tb_ifs.sv
verif/etg_traj_checker.sv
verif/tb_ellipse_trajectory_generator_unit.sv
